/* hw/rtl/smspdu_pkg.sv */
// shared types and constants for the sms submit pdu encoder
`timescale 1ns / 1ps

package smspdu_pkg;

  // input item kinds, as carried on in_tuser
  typedef enum logic [1:0] {
    ACT_ADDR   = 2'd0,
    ACT_START  = 2'd1,
    ACT_CHAR   = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  // classified item handed from the front end to the executor
  typedef struct packed {
    action_t     act;
    logic        is_digit;
    logic        is_plus;
    logic [7:0]  data;      // digit, capped length or septet, by kind
  } cmd_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_HDR = 2'b10
  } state_t;

  // command queue between front end and executor
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] SMSC_LEN      = 8'h00;
  localparam logic [7:0] FIRST_OCTET   = 8'h01;
  localparam logic [7:0] MSG_REF       = 8'h00;
  localparam logic [7:0] PID_BYTE      = 8'h00;
  localparam logic [7:0] DCS_BYTE      = 8'h00;
  localparam logic [7:0] TYPE_INTL     = 8'h91;
  localparam logic [7:0] TYPE_NATL     = 8'h81;
  localparam logic [3:0] BCD_FILLER    = 4'hF;
  localparam logic [7:0] HDR_FIXED_LEN = 8'd5;   // bytes before the bcd digits

endpackage

/* hw/rtl/smspdu_front.sv */
// front end: accepts input items and classifies them into commands
`timescale 1ns / 1ps

module smspdu_front
  import smspdu_pkg::*;
#(
  parameter int MAX_CHARS = 160
) (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_value [7:0], text_len [15:8]
  input  logic [1:0]  in_tuser,   // action [1:0]
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam logic [7:0] MAX_CHARS_B = 8'(MAX_CHARS);

  logic [7:0] ch;
  logic [7:0] len;
  logic [3:0] digit_full;

  assign ch         = in_tdata[7:0];
  assign len        = in_tdata[15:8];
  assign digit_full = 4'(ch - CHAR_ZERO);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.act      = action_t'(in_tuser);
    q_cmd.is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    q_cmd.is_plus  = (ch == CHAR_PLUS);
    unique case (action_t'(in_tuser))
      ACT_ADDR:   q_cmd.data = {4'd0, digit_full};
      ACT_START:  q_cmd.data = (len > MAX_CHARS_B) ? MAX_CHARS_B : len;
      ACT_CHAR:   q_cmd.data = {1'b0, ch[6:0]};
      ACT_FINISH: q_cmd.data = 8'd0;
      default:    q_cmd.data = 8'd0;
    endcase
  end

endmodule

/* hw/rtl/smspdu_fifo.sv */
// short command queue between the front end and the executor
`timescale 1ns / 1ps

module smspdu_fifo
  import smspdu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_cmd
);

  cmd_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/smspdu_back.sv */
// executor: address store, header sequencer, septet packer and output register
`timescale 1ns / 1ps

module smspdu_back
  import smspdu_pkg::*;
#(
  parameter int MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // pdu_byte [7:0], byte_position [15:8]
  output logic        out_tlast,
  output logic [2:0]  out_tuser    // byte_valid [0], message_done [1], digit_overflow [2]
);

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int NPAIRS = (MAX_DIGITS + 1) / 2;
  localparam int PAIR_W = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic               intl_r, intl_nxt;
  logic               first_r, first_nxt;
  logic [7:0]         chars_rem_r, chars_rem_nxt;
  logic [7:0]         acc_r, acc_nxt;
  logic [2:0]         off_r, off_nxt;
  logic [7:0]         pos_r, pos_nxt;
  logic               ovf_r, ovf_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic [7:0]         out_pos_r, out_pos_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_bvalid_r, out_bvalid_nxt;
  logic               out_done_r, out_done_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  // bcd digit pairs, low nibble first digit; undefined until written
  logic [7:0]         pair_r [NPAIRS];
  logic               dig_we;
  logic [PAIR_W-1:0]  dig_half;

  logic               slot_free;
  logic [7:0]         hdr_byte;
  logic               hdr_last;
  logic [7:0]         hdr_diff;
  logic [7:0]         hdr_tail;
  logic [7:0]         npairs;
  logic [CNT_W:0]     npairs_w;
  logic [7:0]         pair_rd;
  logic [8:0]         hi_idx;
  logic [7:0]         sep8;
  logic [7:0]         acc_or;

  assign slot_free = !out_valid_r || out_tready;
  assign dig_half  = PAIR_W'(dig_cnt_r >> 1);
  assign npairs_w  = ({1'b0, dig_cnt_r} + (CNT_W+1)'(1)) >> 1;
  assign npairs    = 8'(npairs_w);
  assign hdr_diff  = pos_r - HDR_FIXED_LEN;
  assign hdr_tail  = hdr_diff - npairs;
  assign pair_rd   = pair_r[hdr_diff[PAIR_W-1:0]];
  assign hi_idx    = {hdr_diff, 1'b1};
  assign sep8      = q_cmd.data;
  assign acc_or    = acc_r | (sep8 << off_r);

  // header byte for the current position
  always_comb begin
    hdr_byte = 8'd0;
    hdr_last = 1'b0;
    if (pos_r < HDR_FIXED_LEN) begin
      case (pos_r[2:0])
        3'd0:    hdr_byte = SMSC_LEN;
        3'd1:    hdr_byte = FIRST_OCTET;
        3'd2:    hdr_byte = MSG_REF;
        3'd3:    hdr_byte = 8'(dig_cnt_r);
        3'd4:    hdr_byte = intl_r ? TYPE_INTL : TYPE_NATL;
        default: hdr_byte = 8'd0;
      endcase
    end else if (hdr_diff < npairs) begin
      hdr_byte[3:0] = pair_rd[3:0];
      // odd count: the last pair gets the filler nibble
      hdr_byte[7:4] = (hi_idx < 9'(dig_cnt_r)) ? pair_rd[7:4] : BCD_FILLER;
    end else if (hdr_tail == 8'd2) begin
      hdr_byte = chars_rem_r;
      hdr_last = 1'b1;
    end else begin
      hdr_byte = (hdr_tail == 8'd0) ? PID_BYTE : DCS_BYTE;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    dig_cnt_nxt    = dig_cnt_r;
    intl_nxt       = intl_r;
    first_nxt      = first_r;
    chars_rem_nxt  = chars_rem_r;
    acc_nxt        = acc_r;
    off_nxt        = off_r;
    pos_nxt        = pos_r;
    ovf_nxt        = ovf_r;
    q_pop          = 1'b0;
    dig_we         = 1'b0;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    out_bvalid_nxt = out_bvalid_r;
    out_done_nxt   = out_done_r;
    out_ovf_nxt    = out_ovf_r;

    unique case (state_r)
      ST_RUN: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.act)
            ACT_ADDR: begin
              if (first_r) begin
                intl_nxt  = q_cmd.is_plus;
                first_nxt = 1'b0;
              end
              if (q_cmd.is_digit) begin
                if (dig_cnt_r < CNT_W'(MAX_DIGITS)) begin
                  dig_we      = 1'b1;
                  dig_cnt_nxt = dig_cnt_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            ACT_START: begin
              chars_rem_nxt = q_cmd.data;
              acc_nxt       = 8'd0;
              off_nxt       = 3'd0;
              pos_nxt       = 8'd0;
              state_nxt     = ST_HDR;
            end
            ACT_CHAR: begin
              if (chars_rem_r != 8'd0) begin
                chars_rem_nxt = chars_rem_r - 8'd1;
                if (off_r == 3'd0) begin
                  acc_nxt = acc_or;
                  off_nxt = 3'd7;
                end else begin
                  // a full byte has gathered
                  out_valid_nxt  = 1'b1;
                  out_byte_nxt   = acc_or;
                  out_pos_nxt    = pos_r;
                  out_last_nxt   = 1'b1;
                  out_bvalid_nxt = 1'b1;
                  out_done_nxt   = 1'b0;
                  out_ovf_nxt    = ovf_r;
                  pos_nxt        = pos_r + 8'd1;
                  acc_nxt        = sep8 >> (4'd8 - {1'b0, off_r});
                  off_nxt        = off_r - 3'd1;
                end
              end
            end
            ACT_FINISH: begin
              out_valid_nxt  = 1'b1;
              out_byte_nxt   = (off_r != 3'd0) ? acc_r : 8'd0;
              out_pos_nxt    = (off_r != 3'd0) ? pos_r : 8'd0;
              out_last_nxt   = 1'b1;
              out_bvalid_nxt = (off_r != 3'd0);
              out_done_nxt   = 1'b1;
              out_ovf_nxt    = ovf_r;
              dig_cnt_nxt    = '0;
              intl_nxt       = 1'b0;
              first_nxt      = 1'b1;
              ovf_nxt        = 1'b0;
              chars_rem_nxt  = 8'd0;
              acc_nxt        = 8'd0;
              off_nxt        = 3'd0;
              pos_nxt        = 8'd0;
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = hdr_byte;
          out_pos_nxt    = pos_r;
          out_last_nxt   = hdr_last;
          out_bvalid_nxt = 1'b1;
          out_done_nxt   = 1'b0;
          out_ovf_nxt    = ovf_r;
          pos_nxt        = pos_r + 8'd1;
          if (hdr_last) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      dig_cnt_r   <= '0;
      intl_r      <= 1'b0;
      first_r     <= 1'b1;
      chars_rem_r <= 8'd0;
      acc_r       <= 8'd0;
      off_r       <= 3'd0;
      pos_r       <= 8'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      intl_r      <= intl_nxt;
      first_r     <= first_nxt;
      chars_rem_r <= chars_rem_nxt;
      acc_r       <= acc_nxt;
      off_r       <= off_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_done_r   <= out_done_nxt;
    out_ovf_r    <= out_ovf_nxt;
    if (dig_we) begin
      if (dig_cnt_r[0]) begin
        pair_r[dig_half][7:4] <= q_cmd.data[3:0];
      end else begin
        pair_r[dig_half][3:0] <= q_cmd.data[3:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_done_r, out_bvalid_r};

  // a finish result always closes its run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("finish result without last");

  // an empty finish result carries zero byte and position
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bvalid_r |-> (out_byte_r == 8'd0) && (out_pos_r == 8'd0)
      && out_done_r)
    else $error("empty result with payload");

  // the header sequencer owns the executor
  a_no_pop_in_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HDR |-> !q_pop)
    else $error("command taken during header");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dig_cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count past capacity");

  // a header never runs past its final length byte
  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HDR |-> pos_r < (HDR_FIXED_LEN + npairs + 8'd3))
    else $error("header overran");

endmodule

/* hw/rtl/sms_submit_pdu_encoder.sv */
// path: an item goes through the command queue and the output register, a header byte also
// through the start dispatch; in the run state the executor takes a new address, char or finish
// item whenever the output slot is free; a start is followed by 8 + ceil(digits/2) header bytes
// a four-entry command queue lets input acceptance run ahead of the header sequencer
// reset: rst_n synchronous active low clears queue, state machine and output valid flag
// the bcd digit store is not cleared and is only read below the digit count
`timescale 1ns / 1ps

module sms_submit_pdu_encoder
  import smspdu_pkg::*;
#(
  parameter int MAX_DIGITS = 20,
  parameter int MAX_CHARS  = 160
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_value [7:0], text_len [15:8]
  input  logic [1:0]  in_tuser,   // action [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pdu_byte [7:0], byte_position [15:8]
  output logic        out_tlast,  // last
  output logic [2:0]  out_tuser   // byte_valid [0], message_done [1], digit_overflow [2]
);

  logic q_full;
  logic q_push;
  cmd_t q_in_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_out_cmd;

  smspdu_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  smspdu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_cmd   (q_out_cmd)
  );

  smspdu_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_out_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* tb/sv/sms_pdu_checker.sv */
// checker for the sms submit pdu encoder: predicts pdu bytes and compares them
`timescale 1ns / 1ps

module sms_pdu_checker
  import smspdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // char_value [7:0], text_len [15:8]
  input  logic [1:0]  in_tuser,   // action [1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // pdu_byte [7:0], byte_position [15:8]
  input  logic        out_tlast,  // last
  input  logic [2:0]  out_tuser,  // byte_valid [0], message_done [1], digit_overflow [2]
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int ADDR_DIGITS = 20;
  localparam int TEXT_CAP    = 160;

  typedef struct {
    logic [7:0] pdu_byte;
    logic       byte_valid;
    logic [7:0] position;
    logic       last;
    logic       done;
    logic       overflow;
  } pdu_out_t;

  pdu_out_t   pdu_bytes_due[$];

  // predicted encoder state
  logic [3:0] dig_mem [ADDR_DIGITS];
  logic [4:0] dig_cnt;
  logic       intl;
  logic       addr_fresh;
  logic [7:0] quota;
  logic [7:0] pack_acc;
  logic [2:0] pack_off;
  logic [7:0] pos;
  logic       dropped_digits;

  pdu_out_t   got;
  pdu_out_t   want;

  task automatic clear_text();
    quota    = '0;
    pack_acc = '0;
    pack_off = '0;
    pos      = '0;
  endtask

  task automatic clear_addr();
    dig_cnt        = '0;
    intl           = 1'b0;
    addr_fresh     = 1'b1;
    dropped_digits = 1'b0;
  endtask

  task automatic queue_byte(logic [7:0] b, logic vld, logic [7:0] p, logic lst, logic dn);
    pdu_out_t r;
    r.pdu_byte   = b;
    r.byte_valid = vld;
    r.position   = p;
    r.last       = lst;
    r.done       = dn;
    r.overflow   = dropped_digits;
    pdu_bytes_due.push_back(r);
  endtask

  task automatic emit_next(logic [7:0] b, logic lst);
    queue_byte(b, 1'b1, pos, lst, 1'b0);
    pos = pos + 8'd1;
  endtask

  task automatic encode_item(action_t act, logic [7:0] ch, logic [7:0] len);
    logic [7:0] septet;
    logic [7:0] bcd;
    logic [3:0] nxt;
    case (act)
      ACT_ADDR: begin
        if (addr_fresh) begin
          intl       = (ch == CHAR_PLUS);
          addr_fresh = 1'b0;
        end
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
          if (dig_cnt < ADDR_DIGITS) begin
            dig_mem[dig_cnt] = 4'(ch - CHAR_ZERO);
            dig_cnt = dig_cnt + 5'd1;
          end else begin
            dropped_digits = 1'b1;
          end
        end
      end
      ACT_START: begin
        clear_text();
        if (len > TEXT_CAP) len = 8'(TEXT_CAP);
        emit_next(SMSC_LEN, 1'b0);
        emit_next(FIRST_OCTET, 1'b0);
        emit_next(MSG_REF, 1'b0);
        emit_next({3'b000, dig_cnt}, 1'b0);
        emit_next(intl ? TYPE_INTL : TYPE_NATL, 1'b0);
        // digits pairwise, low nibble first, filler on an odd tail
        for (int i = 0; i < dig_cnt; i += 2) begin
          bcd = {BCD_FILLER, dig_mem[i]};
          if (i + 1 < dig_cnt) bcd[7:4] = dig_mem[i + 1];
          emit_next(bcd, 1'b0);
        end
        emit_next(PID_BYTE, 1'b0);
        emit_next(DCS_BYTE, 1'b0);
        emit_next(len, 1'b1);
        quota = len;
      end
      ACT_CHAR: begin
        if (quota != 0) begin
          quota    = quota - 8'd1;
          septet   = {1'b0, ch[6:0]};
          pack_acc = pack_acc | (septet << pack_off);
          nxt      = {1'b0, pack_off} + 4'd7;
          if (nxt >= 4'd8) begin
            emit_next(pack_acc, 1'b1);
            nxt      = nxt - 4'd8;
            pack_acc = septet >> (4'd7 - nxt);
          end
          pack_off = nxt[2:0];
        end
      end
      default: begin
        if (pack_off != 0) queue_byte(pack_acc, 1'b1, pos, 1'b1, 1'b1);
        else queue_byte(8'h00, 1'b0, 8'h00, 1'b1, 1'b1);
        clear_text();
        clear_addr();
      end
    endcase
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_text();
      clear_addr();
      pdu_bytes_due.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (in_tvalid && in_tready)
        encode_item(action_t'(in_tuser), in_tdata[7:0], in_tdata[15:8]);
      if (out_tvalid && out_tready) begin
        got.pdu_byte   = out_tdata[7:0];
        got.position   = out_tdata[15:8];
        got.last       = out_tlast;
        got.byte_valid = out_tuser[0];
        got.done       = out_tuser[1];
        got.overflow   = out_tuser[2];
        if (pdu_bytes_due.size() == 0) begin
          $error("unexpected item: pdu_byte 0x%0h at position %0d", got.pdu_byte,
                 got.position);
          fail_count++;
        end else begin
          want = pdu_bytes_due.pop_front();
          check_field("pdu_byte", want.pdu_byte, got.pdu_byte);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("byte_position", want.position, got.position);
          check_field("last", want.last, got.last);
          check_field("message_done", want.done, got.done);
          check_field("digit_overflow", want.overflow, got.overflow);
          checked++;
        end
      end
    end
    pending = pdu_bytes_due.size();
  end

endmodule

/* tb/sv/tb_sms_submit_pdu_encoder.sv */
// testbench top for the sms submit pdu encoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_sms_submit_pdu_encoder
  import smspdu_pkg::*;
();

  localparam int TARGET_ITEMS = 360;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // char_value [7:0], text_len [15:8]
  logic [1:0]  in_tuser;   // action [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // pdu_byte [7:0], byte_position [15:8]
  logic        out_tlast;  // last
  logic [2:0]  out_tuser;  // byte_valid [0], message_done [1], digit_overflow [2]

  int fail_count;
  int pending;
  int checked;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int items_sent;
  int useful_items;
  int messages;
  int phase_end;

  sms_submit_pdu_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  sms_pdu_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #4 clk = ~clk;

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin : rx_side
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    out_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left   = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(action_t act, logic [7:0] ch, logic [7:0] len, bit counts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {len, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (counts) useful_items++;
  endtask

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) c = c ^ 8'h80;
    return c;
  endfunction

  // one message: mostly well-formed, sometimes broken or noisy
  task automatic send_message(bit full_text);
    int ndig;
    int len;
    int cap;
    int nchar;
    int r;
    messages++;
    if ($urandom_range(99) < 5) begin
      for (int k = 0; k < $urandom_range(1, 3); k++)
        send_item(ACT_CHAR, 8'($urandom), 8'($urandom), 1'b0);
    end
    if ($urandom_range(1)) send_item(ACT_ADDR, CHAR_PLUS, 8'($urandom), 1'b1);
    else if ($urandom_range(99) < 15) send_item(ACT_ADDR, junk_char(), 8'($urandom), 1'b0);
    r = $urandom_range(99);
    if (r < 65)      ndig = $urandom_range(0, 12);
    else if (r < 82) ndig = 20;
    else if (r < 92) ndig = $urandom_range(13, 19);
    else             ndig = $urandom_range(21, 24);
    for (int k = 0; k < ndig; k++) begin
      if ($urandom_range(99) < 8) send_item(ACT_ADDR, junk_char(), 8'($urandom), 1'b0);
      send_item(ACT_ADDR, CHAR_ZERO + 8'($urandom_range(9)), 8'($urandom), 1'b1);
    end
    r = $urandom_range(99);
    if (full_text)   len = 255;
    else if (r < 78) len = $urandom_range(0, 14);
    else if (r < 95) len = $urandom_range(15, 40);
    else             len = $urandom_range(161, 255);
    send_item(ACT_START, 8'($urandom), 8'(len), 1'b1);
    if (!full_text && $urandom_range(99) < 10) begin
      len = $urandom_range(0, 20);
      send_item(ACT_START, 8'($urandom), 8'(len), 1'b1);
    end
    cap = (len > 160) ? 160 : len;
    // large lengths get only a few characters unless a full text is wanted
    if (len > 160 && !full_text) cap = $urandom_range(0, 8);
    nchar = ($urandom_range(99) < 80) ? cap : $urandom_range(0, cap);
    for (int k = 0; k < nchar; k++) send_item(ACT_CHAR, 8'($urandom), 8'($urandom), 1'b1);
    // characters past the quota are ignored
    if (nchar == cap && len <= 160) begin
      for (int k = 0; k < $urandom_range(0, 2); k++)
        send_item(ACT_CHAR, 8'($urandom), 8'($urandom), 1'b0);
    end
    if ($urandom_range(99) < 92) send_item(ACT_FINISH, 8'($urandom), 8'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = ACT_ADDR;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    items_sent     = 0;
    useful_items   = 0;
    messages       = 0;
    phase_end      = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty finish, then a character with no message open
    send_item(ACT_FINISH, 8'h00, 8'h00, 1'b1);
    send_item(ACT_CHAR, 8'h41, 8'h05, 1'b0);
    // international number, odd digit count, non-digit skipped
    send_item(ACT_ADDR, CHAR_PLUS, 8'hFF, 1'b1);
    send_item(ACT_ADDR, 8'h31, 8'h00, 1'b1);
    send_item(ACT_ADDR, 8'h32, 8'h00, 1'b1);
    send_item(ACT_ADDR, 8'h33, 8'h00, 1'b1);
    send_item(ACT_ADDR, 8'h78, 8'h00, 1'b0);
    send_item(ACT_START, 8'hFF, 8'h03, 1'b1);
    send_item(ACT_CHAR, 8'h41, 8'h00, 1'b1);
    send_item(ACT_CHAR, 8'hFF, 8'hFF, 1'b1);
    send_item(ACT_CHAR, 8'h00, 8'h00, 1'b1);
    send_item(ACT_CHAR, 8'h7F, 8'h00, 1'b0);
    send_item(ACT_FINISH, 8'h00, 8'h00, 1'b1);
    // national number, even digit count, capped length, repeated start
    send_item(ACT_ADDR, CHAR_NINE, 8'h00, 1'b1);
    send_item(ACT_ADDR, CHAR_ZERO, 8'h00, 1'b1);
    send_item(ACT_START, 8'h00, 8'hFF, 1'b1);
    send_item(ACT_CHAR, 8'h80, 8'h00, 1'b1);
    send_item(ACT_START, 8'h00, 8'h00, 1'b1);
    send_item(ACT_CHAR, 8'h55, 8'h00, 1'b0);
    send_item(ACT_FINISH, 8'hFF, 8'hFF, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (phase == 0) begin
        hold_requests++;
        send_message(1'b0);
        send_message(1'b1);
      end
      // spread the remaining items over the phases left
      phase_end = useful_items + (TARGET_ITEMS - useful_items) / (4 - phase);
      while (useful_items < phase_end) send_message(1'b0);
    end
    in_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (pending != 0) $error("%0d pdu bytes never arrived", pending);
    $display("covered %0d input items in %0d messages, %0d pdu bytes compared",
             items_sent, messages, checked);
    $display("idling: none, sender only, receiver only, both, plus one long receiver hold");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sms_submit_pdu_encoder.f */
hw/rtl/smspdu_pkg.sv
hw/rtl/smspdu_front.sv
hw/rtl/smspdu_fifo.sv
hw/rtl/smspdu_back.sv
hw/rtl/sms_submit_pdu_encoder.sv
tb/sv/sms_pdu_checker.sv
tb/sv/tb_sms_submit_pdu_encoder.sv
